/* rtl/core/kbt_pkg.sv */
// ----------------------------------------------------------------------------
// kbt_pkg
// Shared types and constants for the k-of-n row bitmap threshold block.
// ----------------------------------------------------------------------------
package kbt_pkg;

  localparam int DATA_W      = 64;
  localparam int LANES_DEF   = 64;
  localparam int THR_W       = 5;
  localparam int CNT_W       = THR_W + 1;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = THR_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD  = 1'b0,
    REG_EXACT_MODE = 1'b1
  } cfg_reg_t;

  // classified child request, front to back
  typedef struct packed {
    logic [DATA_W-1:0] hits;
    logic [DATA_W-1:0] valid;
    logic              last;
  } child_req_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

/* rtl/core/kbt_front.sv */
// ----------------------------------------------------------------------------
// kbt_front
// Classifies a child request: per-lane hit word and valid lanes.
// ----------------------------------------------------------------------------
module kbt_front #(
  parameter int LANES = kbt_pkg::LANES_DEF
) (
  input  logic [kbt_pkg::DATA_W-1:0] match_bits,
  input  logic                       negate,
  input  logic [kbt_pkg::DATA_W-1:0] row_mask,
  input  logic                       last_child,
  output kbt_pkg::child_req_t        req
);

  localparam logic [kbt_pkg::DATA_W-1:0] LANE_MASK =
    {kbt_pkg::DATA_W{1'b1}} >> (kbt_pkg::DATA_W - LANES);

  logic [kbt_pkg::DATA_W-1:0] valid;

  assign valid     = row_mask & LANE_MASK;
  assign req.valid = valid;
  assign req.hits  = (negate ? ~match_bits : match_bits) & valid;
  assign req.last  = last_child;

endmodule

/* rtl/core/kbt_queue.sv */
// ----------------------------------------------------------------------------
// kbt_queue
// Short request queue between front and back.
// ----------------------------------------------------------------------------
module kbt_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  kbt_pkg::child_req_t push_req,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output kbt_pkg::child_req_t head_req
);

  kbt_pkg::child_req_t              entries [kbt_pkg::QUEUE_DEPTH];
  logic [kbt_pkg::QPTR_W-1:0]       wr_ptr;
  logic [kbt_pkg::QPTR_W-1:0]       rd_ptr;
  logic [kbt_pkg::QCNT_W-1:0]       count;

  assign full       = (count == kbt_pkg::QCNT_W'(kbt_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_req   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == kbt_pkg::QPTR_W'(kbt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == kbt_pkg::QPTR_W'(kbt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/kbt_back.sv */
// ----------------------------------------------------------------------------
// kbt_back
// Lane match counters, threshold compare and result register.
// ----------------------------------------------------------------------------
module kbt_back #(
  parameter int LANES = kbt_pkg::LANES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  kbt_pkg::cfg_wr_t           cfg,
  input  logic                       head_valid,
  input  kbt_pkg::child_req_t        head_req,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [kbt_pkg::DATA_W-1:0] result_bits
);

  logic [kbt_pkg::THR_W-1:0] threshold;
  logic                      exact_mode;
  logic [kbt_pkg::CNT_W-1:0] counts      [LANES];
  logic [kbt_pkg::CNT_W-1:0] counts_next [LANES];
  logic [kbt_pkg::CNT_W-1:0] cap;
  logic [kbt_pkg::CNT_W-1:0] thr_ext;
  logic [kbt_pkg::DATA_W-1:0] result_next;
  logic                      out_free;

  assign out_free = !out_valid || out_ready;
  assign pop      = head_valid && (!head_req.last || out_free);
  assign thr_ext  = kbt_pkg::CNT_W'(threshold);
  assign cap      = thr_ext + 1'b1;

  always_comb begin
    result_next = '0;
    for (int i = 0; i < LANES; i++) begin
      counts_next[i] = counts[i];
      if (head_req.hits[i] && (counts[i] < cap)) begin
        counts_next[i] = counts[i] + 1'b1;
      end
      result_next[i] = head_req.valid[i] &&
        (exact_mode ? (counts_next[i] == thr_ext) : (counts_next[i] >= thr_ext));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= kbt_pkg::THR_RESET;
      exact_mode <= 1'b0;
    end else if (cfg.we) begin
      unique case (kbt_pkg::cfg_reg_t'(cfg.index))
        kbt_pkg::REG_THRESHOLD:  threshold  <= cfg.data;
        kbt_pkg::REG_EXACT_MODE: exact_mode <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANES; i++) begin
        counts[i] <= '0;
      end
    end else if (pop) begin
      for (int i = 0; i < LANES; i++) begin
        counts[i] <= head_req.last ? '0 : counts_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head_req.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_req.last) begin
      result_bits <= result_next;
    end
  end

endmodule

/* rtl/core/k_of_n_bitmap_threshold.sv */
// ----------------------------------------------------------------------------
// k_of_n_bitmap_threshold
// Per-row k-of-n match count over streamed child bitmap words.
// ----------------------------------------------------------------------------
// One child request is taken per cycle while in_ready is high; each request
// updates every lane's saturating match counter in the back end. A request
// marked last passes through the two-entry queue, and its result word and
// out_valid are registered at the edge on which it pops from the queue. The
// only throttle is the single result register: while a result waits, only
// further non-last requests drain from the queue, and once a last request
// sits at the head the queue fills with one more request and in_ready drops.
// Write threshold and exact_mode only while idle; the block does not check it.
module k_of_n_bitmap_threshold #(
  parameter int LANES = kbt_pkg::LANES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [kbt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kbt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [kbt_pkg::DATA_W-1:0]     match_bits,
  input  logic                           negate,
  input  logic [kbt_pkg::DATA_W-1:0]     row_mask,
  input  logic                           last_child,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [kbt_pkg::DATA_W-1:0]     result_bits
);

  kbt_pkg::child_req_t front_req;
  kbt_pkg::child_req_t head_req;
  kbt_pkg::cfg_wr_t    cfg;
  logic                q_full;
  logic                head_valid;
  logic                pop;
  logic                push;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;
  assign in_ready  = !q_full;
  assign push      = in_valid && in_ready;

  kbt_front #(.LANES(LANES)) u_front (
    .match_bits (match_bits),
    .negate     (negate),
    .row_mask   (row_mask),
    .last_child (last_child),
    .req        (front_req)
  );

  kbt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_req   (front_req),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_req   (head_req)
  );

  kbt_back #(.LANES(LANES)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head_valid  (head_valid),
    .head_req    (head_req),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_bits (result_bits)
  );

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (pop && head_req.last) |=> out_valid)
    else $error("last request did not produce a result");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pop && head_req.last))
    else $error("result without a last request");

  a_result_in_valid_lanes: assert property (@(posedge clk) disable iff (rst)
    (pop && head_req.last) |=> ((result_bits & ~$past(head_req.valid)) == '0))
    else $error("result bit set in an invalid lane");

endmodule

/* dv/k_of_n_bitmap_threshold_test.sv */
// ----------------------------------------------------------------------------
// k_of_n_bitmap_threshold_test
// Self-checking bench for the k-of-n row bitmap threshold block.
// ----------------------------------------------------------------------------
// Child requests go in over a valid/ready channel with random gaps, and result
// words come back with random back-pressure. A behavioral lane counter model
// predicts each untyped result word. A short table of hand-picked requests and
// register writes runs first. Random row groups follow over several
// threshold/mode settings, some of them changed in the middle of a group.
module k_of_n_bitmap_threshold_test;

  localparam int DATA_W = kbt_pkg::DATA_W;
  localparam int THR_W = kbt_pkg::THR_W;
  localparam int CNT_W = kbt_pkg::CNT_W;
  localparam int CFG_IDX_W = kbt_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = kbt_pkg::CFG_DATA_W;
  localparam int LANES = kbt_pkg::LANES_DEF;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 90;
  localparam logic [DATA_W-1:0] ONES = {DATA_W{1'b1}};
  localparam logic [DATA_W-1:0] ZERO = '0;
  localparam logic [DATA_W-1:0] LOW_HALF = 64'h0000_0000_FFFF_FFFF;
  localparam logic [DATA_W-1:0] SPLIT_MASK = 64'hF0F0_F0F0_0F0F_0F0F;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    kbt_pkg::cfg_reg_t cfg_sel;
    logic [THR_W-1:0]  cfg_val;
    logic [DATA_W-1:0] bits;
    logic              neg;
    logic [DATA_W-1:0] mask;
    logic              last;
    logic              known;
    logic [DATA_W-1:0] result;
  } step_row_t;

  localparam int DIRECTED_ROWS = 32;

  // cfg rows: kind, register, value; request rows: bits, negate, mask, last,
  // and a typed result word where known is set
  step_row_t directed [DIRECTED_ROWS] = '{
    '{ROW_REQ, kbt_pkg::REG_THRESHOLD, 5'd0, ONES, 1'b0, ONES, 1'b1, 1'b1, ONES},
    '{ROW_REQ, kbt_pkg::REG_THRESHOLD, 5'd0, ZERO, 1'b0, ONES, 1'b1, 1'b1, ZERO},
    '{ROW_REQ, kbt_pkg::REG_THRESHOLD, 5'd0, ZERO, 1'b1, ONES, 1'b1, 1'b1, ONES},
    '{ROW_REQ, kbt_pkg::REG_THRESHOLD, 5'd0, ONES, 1'b1, ONES, 1'b1, 1'b1, ZERO},
    '{ROW_REQ, kbt_pkg::REG_THRESHOLD, 5'd0, ZERO, 1'b1, LOW_HALF, 1'b1, 1'b1,
      LOW_HALF},
    '{ROW_REQ, kbt_pkg::REG_THRESHOLD, 5'd0, ONES, 1'b0, ZERO, 1'b1, 1'b1, ZERO},
    '{ROW_REQ, kbt_pkg::REG_THRESHOLD, 5'd0, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0, ONES,
      1'b0, 1'b0, ZERO},
    '{ROW_REQ, kbt_pkg::REG_THRESHOLD, 5'd0, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, ONES,
      1'b1, 1'b1, ONES},
    '{ROW_CFG, kbt_pkg::REG_THRESHOLD, 5'd31, ZERO, 1'b0, ZERO, 1'b0, 1'b0, ZERO},
    '{ROW_CFG, kbt_pkg::REG_EXACT_MODE, 5'd0, ZERO, 1'b0, ZERO, 1'b0, 1'b0, ZERO},
    '{ROW_REQ, kbt_pkg::REG_THRESHOLD, 5'd0, ONES, 1'b0, ONES, 1'b0, 1'b0, ZERO},
    '{ROW_REQ, kbt_pkg::REG_THRESHOLD, 5'd0, ONES, 1'b0, ONES, 1'b1, 1'b1, ZERO},
    '{ROW_CFG, kbt_pkg::REG_THRESHOLD, 5'd0, ZERO, 1'b0, ZERO, 1'b0, 1'b0, ZERO},
    '{ROW_CFG, kbt_pkg::REG_EXACT_MODE, 5'd1, ZERO, 1'b0, ZERO, 1'b0, 1'b0, ZERO},
    '{ROW_REQ, kbt_pkg::REG_THRESHOLD, 5'd0, 64'h00FF_00FF_00FF_00FF, 1'b0, ONES,
      1'b1, 1'b1, 64'hFF00_FF00_FF00_FF00},
    '{ROW_REQ, kbt_pkg::REG_THRESHOLD, 5'd0, ZERO, 1'b1, 64'hF0F0_F0F0_F0F0_F0F0,
      1'b1, 1'b1, ZERO},
    '{ROW_CFG, kbt_pkg::REG_EXACT_MODE, 5'd0, ZERO, 1'b0, ZERO, 1'b0, 1'b0, ZERO},
    '{ROW_REQ, kbt_pkg::REG_THRESHOLD, 5'd0, 64'h1234_5678_9ABC_DEF0, 1'b0,
      SPLIT_MASK, 1'b1, 1'b1, SPLIT_MASK},
    '{ROW_CFG, kbt_pkg::REG_THRESHOLD, 5'd2, ZERO, 1'b0, ZERO, 1'b0, 1'b0, ZERO},
    '{ROW_CFG, kbt_pkg::REG_EXACT_MODE, 5'd1, ZERO, 1'b0, ZERO, 1'b0, 1'b0, ZERO},
    '{ROW_REQ, kbt_pkg::REG_THRESHOLD, 5'd0, 64'hFFFF_0000_FFFF_0000, 1'b0, ONES,
      1'b0, 1'b0, ZERO},
    '{ROW_REQ, kbt_pkg::REG_THRESHOLD, 5'd0, 64'hFF00_FF00_FF00_FF00, 1'b0, ONES,
      1'b0, 1'b0, ZERO},
    '{ROW_REQ, kbt_pkg::REG_THRESHOLD, 5'd0, 64'hF0F0_F0F0_F0F0_F0F0, 1'b0, ONES,
      1'b1, 1'b0, ZERO},
    '{ROW_CFG, kbt_pkg::REG_THRESHOLD, 5'd3, ZERO, 1'b0, ZERO, 1'b0, 1'b0, ZERO},
    '{ROW_CFG, kbt_pkg::REG_EXACT_MODE, 5'd0, ZERO, 1'b0, ZERO, 1'b0, 1'b0, ZERO},
    '{ROW_REQ, kbt_pkg::REG_THRESHOLD, 5'd0, ONES, 1'b0, ONES, 1'b0, 1'b0, ZERO},
    '{ROW_REQ, kbt_pkg::REG_THRESHOLD, 5'd0, ONES, 1'b0, ONES, 1'b0, 1'b0, ZERO},
    '{ROW_REQ, kbt_pkg::REG_THRESHOLD, 5'd0, ONES, 1'b0, ONES, 1'b0, 1'b0, ZERO},
    '{ROW_REQ, kbt_pkg::REG_THRESHOLD, 5'd0, ONES, 1'b0, ONES, 1'b0, 1'b0, ZERO},
    // threshold lowered mid-group: counters already past the new cap hold
    '{ROW_CFG, kbt_pkg::REG_THRESHOLD, 5'd1, ZERO, 1'b0, ZERO, 1'b0, 1'b0, ZERO},
    '{ROW_CFG, kbt_pkg::REG_EXACT_MODE, 5'd1, ZERO, 1'b0, ZERO, 1'b0, 1'b0, ZERO},
    '{ROW_REQ, kbt_pkg::REG_THRESHOLD, 5'd0, ONES, 1'b0, ONES, 1'b1, 1'b1, ZERO}
  };

  int phase_thr [6] = '{1, 31, 0, 2, 31, 0};
  logic phase_exact [6] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [DATA_W-1:0]     match_bits = '0;
  logic                  negate = 1'b0;
  logic [DATA_W-1:0]     row_mask = '0;
  logic                  last_child = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [DATA_W-1:0]     result_bits;

  logic [CNT_W-1:0]  lane_count [LANES];
  logic [THR_W-1:0]  thr_now;
  logic              exact_now;
  logic [DATA_W-1:0] pending_results [$];
  logic [DATA_W-1:0] group_mask;
  int                group_left;
  int                children_sent;
  int                results_seen;
  int                failures;

  k_of_n_bitmap_threshold dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .match_bits (match_bits),
    .negate     (negate),
    .row_mask   (row_mask),
    .last_child (last_child),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_bits(result_bits)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("** k_of_n_bitmap_threshold: FAILED **");
    $finish;
  end

  // counts one child into the lanes; returns the row word when it closes a group
  function automatic logic [DATA_W-1:0] tally_child(logic [DATA_W-1:0] bits, logic neg,
                                                    logic [DATA_W-1:0] mask, logic last);
    logic [DATA_W-1:0] hits;
    logic [DATA_W-1:0] passed;
    logic [CNT_W-1:0]  cap;
    logic              ok;
    passed = '0;
    hits = (neg ? ~bits : bits) & mask;
    cap = CNT_W'(thr_now) + CNT_W'(1);
    for (int i = 0; i < LANES; i++) begin
      if (hits[i] && lane_count[i] < cap) begin
        lane_count[i] = lane_count[i] + CNT_W'(1);
      end
    end
    if (last) begin
      for (int i = 0; i < LANES; i++) begin
        ok = exact_now ? (lane_count[i] == CNT_W'(thr_now)) : (lane_count[i] >= CNT_W'(thr_now));
        passed[i] = ok & mask[i];
        lane_count[i] = '0;
      end
    end
    return passed;
  endfunction

  function automatic void note_failure(string what, logic [DATA_W-1:0] want,
                                       logic [DATA_W-1:0] got);
    failures++;
    if (failures <= 10) begin
      $display("%0t: %s: expected %h, got %h", $time, what, want, got);
    end
  endfunction

  task automatic offer_child(input logic [DATA_W-1:0] bits, input logic neg,
                             input logic [DATA_W-1:0] mask, input logic last,
                             input logic known, input logic [DATA_W-1:0] typed);
    int                gap;
    logic [DATA_W-1:0] row_word;
    gap = (((children_sent / 40) % 3) == 2) ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    match_bits <= bits;
    negate <= neg;
    row_mask <= mask;
    last_child <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    children_sent++;
    row_word = tally_child(bits, neg, mask, last);
    if (last) begin
      pending_results.push_back(known ? typed : row_word);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input kbt_pkg::cfg_reg_t sel, input logic [THR_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (sel)
      kbt_pkg::REG_THRESHOLD: thr_now = val;
      kbt_pkg::REG_EXACT_MODE: exact_now = val[0];
    endcase
    @(posedge clk);
  endtask

  task automatic random_children(input int count);
    logic [DATA_W-1:0] bits;
    logic [DATA_W-1:0] mask;
    logic              neg;
    int                thr_int;
    int                span_lo;
    for (int n = 0; n < count; n++) begin
      if (group_left == 0) begin
        thr_int = thr_now;
        span_lo = (thr_int > 1) ? thr_int - 1 : 1;
        group_left = ($urandom_range(0, 9) < 7) ? $urandom_range(span_lo, thr_int + 2)
                                                : $urandom_range(1, 8);
        case ($urandom_range(0, 9))
          0, 1: group_mask = {$urandom, $urandom};
          2: group_mask = ONES >> $urandom_range(0, 63);
          default: group_mask = ONES;
        endcase
      end
      case ($urandom_range(0, 5))
        0: bits = ONES;
        1: bits = ZERO;
        2: bits = {$urandom, $urandom};
        3: bits = {$urandom, $urandom} | {$urandom, $urandom};
        4: bits = {$urandom, $urandom} & {$urandom, $urandom};
        default: bits = ~({$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom});
      endcase
      neg = ($urandom_range(0, 3) == 0);
      mask = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : group_mask;
      offer_child(bits, neg, mask, group_left == 1, 1'b0, ZERO);
      group_left--;
    end
  endtask

  // result side: random stalls plus two long hold-offs to back up the input
  initial begin
    int                hold;
    logic [DATA_W-1:0] want;
    while (rst) @(posedge clk);
    forever begin
      if (results_seen == 15 || results_seen == 80) begin
        hold = 80;
      end else if (((results_seen / 8) % 3) == 2) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 9);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (pending_results.size() == 0) begin
        note_failure("result with nothing pending", ZERO, result_bits);
      end else begin
        want = pending_results.pop_front();
        if (result_bits !== want) begin
          note_failure("result_bits mismatch", want, result_bits);
        end
      end
      results_seen++;
    end
  end

  initial begin
    for (int i = 0; i < LANES; i++) begin
      lane_count[i] = '0;
    end
    thr_now = kbt_pkg::THR_RESET;
    exact_now = 1'b0;
    group_left = 0;
    group_mask = ONES;
    children_sent = 0;
    results_seen = 0;
    failures = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (directed[r].kind == ROW_CFG) begin
        wait_idle();
        write_cfg(directed[r].cfg_sel, directed[r].cfg_val);
      end else begin
        offer_child(directed[r].bits, directed[r].neg, directed[r].mask, directed[r].last,
                    directed[r].known, directed[r].result);
      end
    end

    // phase boundaries fall wherever the item count lands, often mid-group
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      if (p < 6) begin
        write_cfg(kbt_pkg::REG_THRESHOLD, THR_W'(phase_thr[p]));
        write_cfg(kbt_pkg::REG_EXACT_MODE, THR_W'(phase_exact[p]));
      end else begin
        write_cfg(kbt_pkg::REG_THRESHOLD, THR_W'($urandom_range(1, 31)));
        write_cfg(kbt_pkg::REG_EXACT_MODE, THR_W'($urandom_range(0, 1)));
      end
      random_children(PHASE_ITEMS);
    end

    wait_idle();
    if (failures == 0) begin
      $display("** k_of_n_bitmap_threshold: PASSED **");
    end else begin
      $display("** k_of_n_bitmap_threshold: FAILED **");
    end
    $finish;
  end

endmodule
